[rtl/lvd_pkg.sv]
// Shared types and constants for the edit distance core.
package lvd_pkg;

   localparam int SYM_W    = 8;
   localparam int OP_W     = 2;
   localparam int DIST_W   = 6;
   localparam int DIST_MAX = 63;

   typedef enum logic [OP_W-1:0] {
      OP_APPEND = 2'd0,
      OP_CLEAR  = 2'd1,
      OP_QUERY  = 2'd2,
      OP_EMIT   = 2'd3
   } op_type;

   typedef enum logic {
      KIND_QUERY = 1'b0,
      KIND_EMIT  = 1'b1
   } kind_type;

   typedef struct packed {
      logic     valid;
      kind_type kind;
   } tok_type;

endpackage

[rtl/lvd_cell.sv]
// One column of the edit distance row: reference byte, cost and wavefront stage.
module lvd_cell #(
   parameter int CW  = 6,
   parameter int IDX = 0
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      row_reset,
   input  logic                      ref_clear,
   input  logic                      wr_en,
   input  logic [lvd_pkg::SYM_W-1:0] wr_sym,
   input  lvd_pkg::tok_type          tok_i,
   input  logic [lvd_pkg::SYM_W-1:0] sym_i,
   input  logic [CW-1:0]             cur_i,
   input  logic [CW-1:0]             prev_i,
   output lvd_pkg::tok_type          tok_o,
   output logic [lvd_pkg::SYM_W-1:0] sym_o,
   output logic [CW-1:0]             cur_o,
   output logic [CW-1:0]             prev_o
);

   localparam logic [CW-1:0] INIT = CW'(IDX + 1);

   logic [lvd_pkg::SYM_W-1:0] char_ff;
   logic                      act_ff, act_in;
   logic [CW-1:0]             cost_ff, cost_in;
   lvd_pkg::tok_type          tok_ff;
   logic [lvd_pkg::SYM_W-1:0] sym_ff;
   logic [CW-1:0]             cur_ff, cur_in;
   logic [CW-1:0]             prev_ff, prev_in;

   logic [CW:0] c_left, c_up, c_diag, c_min;

   always_comb begin
      c_left = {1'b0, cur_i} + 1'b1;
      c_up   = {1'b0, cost_ff} + 1'b1;
      c_diag = {1'b0, prev_i} + {{CW{1'b0}}, (char_ff != sym_i)};
      c_min  = (c_left < c_up) ? c_left : c_up;
      c_min  = (c_diag < c_min) ? c_diag : c_min;
   end

   always_comb begin
      cost_in = cost_ff;
      cur_in  = cur_i;
      prev_in = prev_i;
      act_in  = act_ff;
      if (tok_i.valid) begin
         if (tok_i.kind == lvd_pkg::KIND_EMIT) begin
            // pick up this column's cost if it holds a reference byte (the last one wins), then restore
            if (act_ff) begin
               cur_in = cost_ff;
            end
            cost_in = INIT;
         end else if (act_ff) begin
            cost_in = c_min[CW-1:0];
            cur_in  = c_min[CW-1:0];
            prev_in = cost_ff;
         end
      end
      if (row_reset) begin
         cost_in = INIT;
      end
      if (ref_clear) begin
         act_in = 1'b0;
      end
      if (wr_en) begin
         act_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff  <= 1'b0;
         cost_ff <= INIT;
         tok_ff  <= '0;
      end else begin
         act_ff  <= act_in;
         cost_ff <= cost_in;
         tok_ff  <= tok_i;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         char_ff <= wr_sym;
      end
      sym_ff  <= sym_i;
      cur_ff  <= cur_in;
      prev_ff <= prev_in;
   end

   assign tok_o  = tok_ff;
   assign sym_o  = sym_ff;
   assign cur_o  = cur_ff;
   assign prev_o = prev_ff;

endmodule

[rtl/levenshtein_edit_distance_core.sv]
// Top level of the edit distance core: request decode, control and cell chain.
//
//  channel | direction | tdata                           | tuser
//  req     | in        | [7:0] symbol                    | [1:0] operation
//  rsp     | out       | [5:0] distance, [6] overflow    | -
//
// A query byte is taken every cycle and walks the chain one cell per cycle.
// Append, clear and end of query wait until the chain is empty, that is until
// the last query byte or end of query that was taken has left the chain.
// The result is registered on rsp once its end of query leaves the last cell;
// an end of query also waits while an earlier result is still held on rsp.
// Synchronous reset restores the row at once; no clearing pass.
module levenshtein_edit_distance_core #(
   parameter int MAX_LEN = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,  // [7:0] symbol
   input  logic [1:0] req_tuser,  // [1:0] operation
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata   // [5:0] distance, [6] overflow, [7] zero
);

   localparam int CW = $clog2(MAX_LEN + 1);
   localparam int XW = (CW > lvd_pkg::DIST_W) ? CW : lvd_pkg::DIST_W;

   lvd_pkg::op_type op;
   logic            acc;
   logic            chain_idle;

   logic [CW-1:0] ref_len_ff, ref_len_in;
   logic [CW-1:0] ql_ff, ql_in;
   logic          ovf_ff, ovf_in;
   logic [CW-1:0] drain_ff, drain_in;
   logic          pend_ovf_ff, pend_ovf_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [lvd_pkg::DIST_W-1:0] rsp_dist_ff, rsp_dist_in;
   logic          rsp_ovf_ff, rsp_ovf_in;

   logic append_ok, row_reset, ref_clear;

   lvd_pkg::tok_type          tok_w  [MAX_LEN+1];
   logic [lvd_pkg::SYM_W-1:0] sym_w  [MAX_LEN+1];
   logic [CW-1:0]             cur_w  [MAX_LEN+1];
   logic [CW-1:0]             prev_w [MAX_LEN+1];

   lvd_pkg::tok_type tok_head;
   logic [CW-1:0]    cur_head;
   logic [CW-1:0]    prev_head;

   logic [XW-1:0] dist_ext;

   assign op         = lvd_pkg::op_type'(req_tuser);
   assign chain_idle = (drain_ff == '0);
   assign req_tready = (op == lvd_pkg::OP_QUERY) ||
                       (chain_idle && ((op != lvd_pkg::OP_EMIT) || !rsp_valid_ff));
   assign acc        = req_tvalid && req_tready;
   assign append_ok  = (ref_len_ff < CW'(MAX_LEN));

   assign dist_ext = XW'(cur_w[MAX_LEN]);

   assign tok_w[0]  = tok_head;
   assign sym_w[0]  = req_tdata;
   assign cur_w[0]  = cur_head;
   assign prev_w[0] = prev_head;

   always_comb begin
      ref_len_in   = ref_len_ff;
      ql_in        = ql_ff;
      ovf_in       = ovf_ff;
      drain_in     = chain_idle ? drain_ff : drain_ff - 1'b1;
      pend_ovf_in  = pend_ovf_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_dist_in  = rsp_dist_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      row_reset    = 1'b0;
      ref_clear    = 1'b0;
      tok_head     = '0;
      cur_head     = ql_ff + 1'b1;
      prev_head    = ql_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (tok_w[MAX_LEN].valid && (tok_w[MAX_LEN].kind == lvd_pkg::KIND_EMIT)) begin
         rsp_valid_in = 1'b1;
         rsp_dist_in  = (dist_ext > XW'(lvd_pkg::DIST_MAX)) ?
                        lvd_pkg::DIST_W'(lvd_pkg::DIST_MAX) : dist_ext[lvd_pkg::DIST_W-1:0];
         rsp_ovf_in   = pend_ovf_ff;
      end

      if (acc) begin
         case (op)
            lvd_pkg::OP_APPEND: begin
               if (append_ok) begin
                  ref_len_in = ref_len_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               row_reset = 1'b1;
               ql_in     = '0;
            end
            lvd_pkg::OP_CLEAR: begin
               ref_len_in = '0;
               ovf_in     = 1'b0;
               row_reset  = 1'b1;
               ref_clear  = 1'b1;
               ql_in      = '0;
            end
            lvd_pkg::OP_QUERY: begin
               if (ql_ff < CW'(MAX_LEN)) begin
                  tok_head.valid = 1'b1;
                  tok_head.kind  = lvd_pkg::KIND_QUERY;
                  ql_in          = ql_ff + 1'b1;
                  drain_in       = CW'(MAX_LEN);
               end else begin
                  ovf_in = 1'b1;
               end
            end
            default: begin
               // end of query: the cost fed into cell 0 is the query length
               tok_head.valid = 1'b1;
               tok_head.kind  = lvd_pkg::KIND_EMIT;
               cur_head       = ql_ff;
               pend_ovf_in    = ovf_ff;
               ovf_in         = 1'b0;
               ql_in          = '0;
               drain_in       = CW'(MAX_LEN);
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_len_ff   <= '0;
         ql_ff        <= '0;
         ovf_ff       <= 1'b0;
         drain_ff     <= '0;
         pend_ovf_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ref_len_ff   <= ref_len_in;
         ql_ff        <= ql_in;
         ovf_ff       <= ovf_in;
         drain_ff     <= drain_in;
         pend_ovf_ff  <= pend_ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_dist_ff <= rsp_dist_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   for (genvar g = 0; g < MAX_LEN; g++) begin : g_cell
      lvd_cell #(
         .CW  (CW),
         .IDX (g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .row_reset (row_reset),
         .ref_clear (ref_clear),
         .wr_en     (acc && (op == lvd_pkg::OP_APPEND) && append_ok &&
                     (ref_len_ff == CW'(g))),
         .wr_sym    (req_tdata),
         .tok_i     (tok_w[g]),
         .sym_i     (sym_w[g]),
         .cur_i     (cur_w[g]),
         .prev_i    (prev_w[g]),
         .tok_o     (tok_w[g+1]),
         .sym_o     (sym_w[g+1]),
         .cur_o     (cur_w[g+1]),
         .prev_o    (prev_w[g+1])
      );
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ovf_ff, rsp_dist_ff};

endmodule

[rtl/lvd_checker.sv]
// Port-level checks for the edit distance core, bound to the top level.
module lvd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic [7:0] req_tdata,
   input logic [1:0] req_tuser,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);

   logic emit_acc;

   assign emit_acc = req_tvalid && req_tready &&
                     (req_tuser == lvd_pkg::OP_EMIT) && (req_tdata == req_tdata);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response dropped or changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   a_query_ready: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && (req_tuser == lvd_pkg::OP_QUERY) |-> req_tready)
      else $error("query byte stalled");

   a_emit_slot: assert property (@(posedge clock) disable iff (reset)
      emit_acc |-> !rsp_tvalid)
      else $error("end of query taken while a result is pending");

   a_emit_latency: assert property (@(posedge clock) disable iff (reset)
      emit_acc |=> !rsp_tvalid)
      else $error("result appeared too early");

endmodule

bind levenshtein_edit_distance_core lvd_checker u_lvd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

[tb/tb_levenshtein_edit_distance_core.sv]
// Self-checking testbench for the edit distance core: directed and random requests, a scoreboard model.
module tb_levenshtein_edit_distance_core;

   localparam int MAX_LEN     = 32;
   localparam int ITEMS       = 400;
   localparam int CYCLE_LIMIT = 400000;
   localparam int LONG_HOLD   = 300;

   typedef struct {
      logic [lvd_pkg::DIST_W-1:0] distance;
      logic                       overflow;
   } distance_result;

   class edit_distance_scoreboard;
      logic [lvd_pkg::SYM_W-1:0] ref_chars [MAX_LEN];
      int unsigned       ref_len;
      int unsigned       qry_len;
      int unsigned       row [MAX_LEN+1];
      logic              ovf_seen;
      distance_result    pending_q [$];
      int unsigned       requests, results, overflow_results, errors;

      function new();
         ref_len = 0;
         ovf_seen = 0;
         requests = 0;
         results = 0;
         overflow_results = 0;
         errors = 0;
         restart_row();
      endfunction

      function void restart_row();
         for (int k = 0; k <= MAX_LEN; k++) row[k] = k;
         qry_len = 0;
      endfunction

      // advance the model on an accepted request
      function void note_request(lvd_pkg::op_type op, logic [lvd_pkg::SYM_W-1:0] sym);
         int unsigned    diag, above, best, d;
         distance_result res;
         requests++;
         case (op)
            lvd_pkg::OP_APPEND: begin
               if (ref_len < MAX_LEN) begin
                  ref_chars[ref_len] = sym;
                  ref_len++;
               end else begin
                  ovf_seen = 1;
               end
               restart_row();
            end
            lvd_pkg::OP_CLEAR: begin
               ref_len = 0;
               ovf_seen = 0;
               restart_row();
            end
            lvd_pkg::OP_QUERY: begin
               if (qry_len < MAX_LEN) begin
                  diag = row[0];
                  qry_len++;
                  row[0] = qry_len;
                  for (int i = 1; i <= ref_len; i++) begin
                     above = row[i];
                     best = diag + ((ref_chars[i-1] != sym) ? 1 : 0);
                     if (row[i-1] + 1 < best) best = row[i-1] + 1;
                     if (above + 1 < best) best = above + 1;
                     row[i] = best;
                     diag = above;
                  end
               end else begin
                  ovf_seen = 1;
               end
            end
            default: begin
               d = (row[ref_len] > lvd_pkg::DIST_MAX) ? lvd_pkg::DIST_MAX : row[ref_len];
               res.distance = d[lvd_pkg::DIST_W-1:0];
               res.overflow = ovf_seen;
               pending_q.push_back(res);
               ovf_seen = 0;
               restart_row();
            end
         endcase
      endfunction

      function void check_result(logic [7:0] data);
         distance_result want;
         results++;
         if (data[6]) overflow_results++;
         if (pending_q.size() == 0) begin
            $error("unexpected result: distance %0d overflow %0d", data[5:0], data[6]);
            errors++;
            return;
         end
         want = pending_q.pop_front();
         if (data[5:0] !== want.distance) begin
            $error("distance: expected %0d, got %0d", want.distance, data[5:0]);
            errors++;
         end
         if (data[6] !== want.overflow) begin
            $error("overflow: expected %0d, got %0d", want.overflow, data[6]);
            errors++;
         end
      endfunction
   endclass

   logic       clock = 0;
   logic       reset = 1;
   logic       req_tvalid = 0;
   logic       req_tready;
   logic [7:0] req_tdata = '0;  // [7:0] symbol
   logic [1:0] req_tuser = '0;  // [1:0] operation
   logic       rsp_tvalid;
   logic       rsp_tready = 0;
   logic [7:0] rsp_tdata;       // [5:0] distance, [6] overflow, [7] zero

   edit_distance_scoreboard sb;
   int unsigned cycle_count = 0;
   int unsigned burst_left = 0;
   bit          hold_off = 0;
   bit          hold_done = 0;

   levenshtein_edit_distance_core #(.MAX_LEN(MAX_LEN)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
   end

   // receiver: stall pattern in phases, plus one long hold-off on demand
   initial begin
      int mode, len;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         mode = $urandom_range(0, 3);
         len = $urandom_range(10, 60);
         for (int n = 0; n < len; n++) begin
            if (hold_off) begin
               rsp_tready <= 0;
               repeat (LONG_HOLD) @(negedge clock);
               hold_off = 0;
               hold_done = 1;
            end
            case (mode)
               0: rsp_tready <= 1;
               1: rsp_tready <= $urandom_range(0, 1);
               2: rsp_tready <= ($urandom_range(0, 7) != 0);
               default: rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
            @(negedge clock);
         end
      end
   end

   function automatic logic [7:0] random_symbol();
      if ($urandom_range(0, 3) != 0) return 8'(8'h61 + $urandom_range(0, 3));
      return 8'($urandom_range(0, 255));
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_request(lvd_pkg::op_type op, logic [7:0] sym);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 15) : $urandom_range(0, 3);
         if (gap > 0) begin
            req_tvalid <= 0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1;
      req_tuser <= op;
      req_tdata <= sym;
      do @(posedge clock); while (!req_tready);
      sb.note_request(op, sym);
      @(negedge clock);
   endtask

   task automatic send_string(lvd_pkg::op_type op, int count);
      for (int n = 0; n < count; n++) send_request(op, random_symbol());
   endtask

   function automatic int random_length();
      if ($urandom_range(0, 7) == 0) return $urandom_range(30, 35);
      return $urandom_range(0, 8);
   endfunction

   task automatic wait_for_results();
      req_tvalid <= 0;
      burst_left = 0;
      while (sb.pending_q.size() != 0) @(negedge clock);
   endtask

   initial begin
      sb = new();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // directed: empty strings, extreme bytes, abandoned query, empty reference
      send_request(lvd_pkg::OP_EMIT, 8'hFF);
      send_request(lvd_pkg::OP_APPEND, 8'h00);
      send_request(lvd_pkg::OP_APPEND, 8'hFF);
      send_request(lvd_pkg::OP_APPEND, 8'h5A);
      send_request(lvd_pkg::OP_QUERY, 8'hFF);
      send_request(lvd_pkg::OP_QUERY, 8'h00);
      send_request(lvd_pkg::OP_EMIT, 8'h00);
      send_request(lvd_pkg::OP_EMIT, 8'h5A);
      send_request(lvd_pkg::OP_CLEAR, 8'hFF);
      send_request(lvd_pkg::OP_QUERY, 8'h41);
      send_request(lvd_pkg::OP_QUERY, 8'h42);
      send_request(lvd_pkg::OP_QUERY, 8'h43);
      send_request(lvd_pkg::OP_EMIT, 8'h00);
      send_request(lvd_pkg::OP_APPEND, 8'h41);
      send_request(lvd_pkg::OP_QUERY, 8'h41);
      send_request(lvd_pkg::OP_APPEND, 8'h42);
      send_request(lvd_pkg::OP_QUERY, 8'h41);
      send_request(lvd_pkg::OP_QUERY, 8'h42);
      send_request(lvd_pkg::OP_EMIT, 8'hA5);
      send_request(lvd_pkg::OP_CLEAR, 8'h00);
      send_request(lvd_pkg::OP_EMIT, 8'h00);
      wait_for_results();

      while (sb.requests < ITEMS) begin
         if (!hold_done && !hold_off && sb.requests > 200) begin
            hold_off = 1;
            for (int q = 0; q < 6; q++) begin
               send_string(lvd_pkg::OP_QUERY, $urandom_range(0, 4));
               send_request(lvd_pkg::OP_EMIT, random_symbol());
            end
         end
         case ($urandom_range(0, 9))
            0: begin
               for (int n = $urandom_range(1, 4); n > 0; n--)
                  send_request(lvd_pkg::op_type'($urandom_range(0, 3)),
                               8'($urandom_range(0, 255)));
            end
            1: begin
               send_string(lvd_pkg::OP_APPEND, $urandom_range(0, 4));
               send_string(lvd_pkg::OP_QUERY, $urandom_range(1, 4));
               send_string(lvd_pkg::OP_APPEND, $urandom_range(1, 3));
               send_string(lvd_pkg::OP_QUERY, random_length());
               send_request(lvd_pkg::OP_EMIT, random_symbol());
            end
            default: begin
               if ($urandom_range(0, 9) < 6)
                  send_request(lvd_pkg::OP_CLEAR, 8'($urandom_range(0, 255)));
               send_string(lvd_pkg::OP_APPEND, random_length());
               for (int q = $urandom_range(1, 3); q > 0; q--) begin
                  send_string(lvd_pkg::OP_QUERY, random_length());
                  send_request(lvd_pkg::OP_EMIT, random_symbol());
               end
            end
         endcase
         if ($urandom_range(0, 11) == 0) wait_for_results();
      end

      wait_for_results();
      repeat (2 * MAX_LEN + 8) @(posedge clock);
      $display("Sent %0d requests; checked %0d distances, %0d of them with overflow set.",
               sb.requests, sb.results, sb.overflow_results);
      if (sb.errors == 0 && sb.pending_q.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
